@@ design/rss_pkg.sv @@
// Shared types, constants and suffix tables of the Russian suffix stemmer.
`default_nettype none

package rss_pkg;

   localparam int LEN_W      = 10;
   localparam int MIN_W      = 6;
   localparam int TAIL_BYTES = 14;
   localparam int TAIL_IDX_W = $clog2(TAIL_BYTES);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] MAX_TOKEN_BYTES = 10'd1023;
   localparam logic [MIN_W-1:0] MIN_STEM_RESET  = 6'd6;

   // Register index, taken from paddr[2].
   localparam logic REG_MIN_STEM = 1'b0;

   localparam int TOKQ_DEPTH = 4;
   localparam int TOKQ_PTR_W = $clog2(TOKQ_DEPTH);
   localparam int TOKQ_CNT_W = $clog2(TOKQ_DEPTH + 1);
   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   localparam logic [7:0] LEAD_D0   = 8'hD0;
   localparam logic [7:0] LEAD_D1   = 8'hD1;
   localparam logic [7:0] TRAIL_ES  = 8'h81;
   localparam logic [7:0] TRAIL_YA  = 8'h8F;
   localparam logic [7:0] TRAIL_SFT = 8'h8C;
   localparam logic [7:0] TRAIL_HRD = 8'h8A;
   localparam logic [7:0] CHAR_0    = 8'h30;
   localparam logic [7:0] CHAR_9    = 8'h39;

   typedef logic [TAIL_BYTES-1:0][7:0] window_type;

   // One finished token as the front hands it over; win[0] is the final byte.
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             too_long;
      logic             eligible;
      window_type       win;
   } token_rec_type;

   typedef struct packed {
      logic [LEN_W-1:0] stem_length;
      logic             was_changed;
      logic             too_long;
   } result_type;

   localparam int ENDING_COUNT = 37;
   localparam int ENDING_MAX   = 8;

   localparam logic [3:0] END_LEN [ENDING_COUNT] = '{
      4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
      4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
      4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
      4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2
   };

   // Ending bytes in text order, first byte in the top octet, zero padded.
   localparam logic [8*ENDING_MAX-1:0] END_BYTES [ENDING_COUNT] = '{
      64'hD0B8_D18F_D0BC_D0B8,
      64'hD18F_D0BC_D0B8_0000,
      64'hD0B0_D0BC_D0B8_0000,
      64'hD18B_D0BC_D0B8_0000,
      64'hD0B8_D0BC_D0B8_0000,
      64'hD0BE_D0B3_D0BE_0000,
      64'hD0B5_D0B3_D0BE_0000,
      64'hD0BE_D0BC_D183_0000,
      64'hD0B5_D0BC_D183_0000,
      64'hD18B_D185_0000_0000,
      64'hD0B8_D185_0000_0000,
      64'hD0B0_D185_0000_0000,
      64'hD18F_D185_0000_0000,
      64'hD0BE_D0B2_0000_0000,
      64'hD0B5_D0B2_0000_0000,
      64'hD0BE_D0BC_0000_0000,
      64'hD0B5_D0BC_0000_0000,
      64'hD0B0_D0BC_0000_0000,
      64'hD18F_D0BC_0000_0000,
      64'hD183_D18E_0000_0000,
      64'hD18E_D18E_0000_0000,
      64'hD0B0_D18F_0000_0000,
      64'hD18F_D18F_0000_0000,
      64'hD0BE_D0B5_0000_0000,
      64'hD0B5_D0B5_0000_0000,
      64'hD18B_D0B9_0000_0000,
      64'hD0B8_D0B9_0000_0000,
      64'hD18B_D0B5_0000_0000,
      64'hD0B8_D0B5_0000_0000,
      64'hD0B0_0000_0000_0000,
      64'hD18F_0000_0000_0000,
      64'hD0BE_0000_0000_0000,
      64'hD0B5_0000_0000_0000,
      64'hD18B_0000_0000_0000,
      64'hD0B8_0000_0000_0000,
      64'hD183_0000_0000_0000,
      64'hD18E_0000_0000_0000
   };

   // Length of the first list ending found at offset off from the end, or zero.
   function automatic logic [3:0] first_ending_len(window_type win, logic [2:0] off);
      logic       found;
      logic       hit;
      logic [3:0] m;
      int         idx;
      found = 1'b0;
      m     = 4'd0;
      for (int k = 0; k < ENDING_COUNT; k++) begin
         hit = 1'b1;
         for (int j = 0; j < ENDING_MAX; j++) begin
            if (j < int'(END_LEN[k])) begin
               idx = int'(off) + int'(END_LEN[k]) - 1 - j;
               if (win[idx[TAIL_IDX_W-1:0]] != END_BYTES[k][8*ENDING_MAX-1-8*j -: 8]) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit && !found) begin
            found = 1'b1;
            m     = END_LEN[k];
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ design/rss_front.sv @@
// Front end: accepts token bytes, keeps running flags and the tail window.
`default_nettype none

module rss_front import rss_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic [7:0]    req_token_byte,
   input  wire logic          req_last_byte,
   input  wire logic          rec_full,
   output logic               rec_push,
   output token_rec_type      rec_data
);

   logic [LEN_W-1:0] count_ff, count_in, count_next;
   logic             digit_ff, digit_in, digit_next;
   logic             lead_ff, lead_in, lead_next;
   logic             ovf_ff, ovf_in, ovf_next;
   window_type       win_ff, win_in, win_next;
   logic             accept;

   assign full   = rec_full;
   assign accept = push && !rec_full;

   always_comb begin
      count_next = (count_ff < MAX_TOKEN_BYTES) ? count_ff + 1'b1 : count_ff;
      ovf_next   = ovf_ff || (count_ff == MAX_TOKEN_BYTES);
      digit_next = digit_ff || ((req_token_byte >= CHAR_0) && (req_token_byte <= CHAR_9));
      lead_next  = lead_ff || (!req_last_byte &&
                   ((req_token_byte == LEAD_D0) || (req_token_byte == LEAD_D1)));
      win_next   = {win_ff[TAIL_BYTES-2:0], req_token_byte};
   end

   always_comb begin
      count_in = count_ff;
      digit_in = digit_ff;
      lead_in  = lead_ff;
      ovf_in   = ovf_ff;
      win_in   = win_ff;
      if (accept) begin
         if (req_last_byte) begin
            count_in = '0;
            digit_in = 1'b0;
            lead_in  = 1'b0;
            ovf_in   = 1'b0;
            win_in   = '0;
         end else begin
            count_in = count_next;
            digit_in = digit_next;
            lead_in  = lead_next;
            ovf_in   = ovf_next;
            win_in   = win_next;
         end
      end
   end

   // The final byte itself never counts as a Cyrillic lead byte.
   assign rec_push          = accept && req_last_byte;
   assign rec_data.len      = count_next;
   assign rec_data.too_long = ovf_next;
   assign rec_data.eligible = !ovf_next && !digit_next && lead_ff;
   assign rec_data.win      = win_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         digit_ff <= 1'b0;
         lead_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         win_ff   <= '0;
      end else begin
         count_ff <= count_in;
         digit_ff <= digit_in;
         lead_ff  <= lead_in;
         ovf_ff   <= ovf_in;
         win_ff   <= win_in;
      end
   end

endmodule

`default_nettype wire

@@ design/rss_tok_queue.sv @@
// Short queue of finished token records between the front and back ends.
`default_nettype none

module rss_tok_queue import rss_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_push,
   input  wire token_rec_type wr_data,
   output logic               wr_full,
   input  wire logic          rd_pop,
   output logic               rd_valid,
   output token_rec_type      rd_data
);

   token_rec_type           mem_ff [TOKQ_DEPTH];
   logic [TOKQ_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [TOKQ_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [TOKQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    do_wr, do_rd;

   assign wr_full  = (cnt_ff == TOKQ_CNT_W'(TOKQ_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rptr_ff];
   assign do_wr    = wr_push && !wr_full;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wptr_in = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ design/rss_back.sv @@
// Back end: two-stage suffix strip pipeline feeding the result queue.
`default_nettype none

module rss_back import rss_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [MIN_W-1:0] min_stem,
   input  wire logic             tok_valid,
   input  wire token_rec_type    tok_data,
   output logic                  tok_pop,
   output logic                  empty,
   input  wire logic             pop,
   output logic [LEN_W-1:0]      rsp_stem_length,
   output logic                  rsp_was_changed,
   output logic                  rsp_too_long
);

   // Stage one: eligibility, reflexive strip and the list search.
   logic             elig0;
   logic             refl;
   logic [LEN_W-1:0] n1;
   logic [2:0]       off1;
   logic [3:0]       m1;
   logic [LEN_W:0]   min_x;

   logic             s1_valid_ff, s1_valid_in;
   token_rec_type    s1_rec_ff, s1_rec_in;
   logic [LEN_W-1:0] s1_n_ff;
   logic [2:0]       s1_off_ff;
   logic [3:0]       s1_m_ff;

   // Stage two: list strip decision and the soft or hard sign.
   logic                  strip;
   logic [LEN_W-1:0]      n2, n3;
   logic [TAIL_IDX_W-1:0] off2, off2_hi;
   logic                  sign;
   result_type            res;
   logic                  s2_fire;

   // Result queue.
   result_type            oq_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] oq_wptr_ff, oq_wptr_in;
   logic [OUTQ_PTR_W-1:0] oq_rptr_ff, oq_rptr_in;
   logic [OUTQ_CNT_W-1:0] oq_cnt_ff, oq_cnt_in;
   logic                  oq_full, oq_rd;

   assign min_x = {{(LEN_W + 1 - MIN_W){1'b0}}, min_stem};

   always_comb begin
      elig0 = tok_data.eligible && (tok_data.len >= LEN_W'(min_stem));
      refl  = elig0
              && (tok_data.win[3] == LEAD_D1) && (tok_data.win[2] == TRAIL_ES)
              && (tok_data.win[1] == LEAD_D1)
              && ((tok_data.win[0] == TRAIL_YA) || (tok_data.win[0] == TRAIL_SFT))
              && ({1'b0, tok_data.len} >= min_x + (LEN_W + 1)'(4));
      n1    = refl ? tok_data.len - LEN_W'(4) : tok_data.len;
      off1  = refl ? 3'd4 : 3'd0;
      m1    = elig0 ? first_ending_len(tok_data.win, off1) : 4'd0;
      s1_rec_in          = tok_data;
      s1_rec_in.eligible = elig0;
   end

   assign oq_full = (oq_cnt_ff == OUTQ_CNT_W'(OUTQ_DEPTH));
   assign s2_fire = s1_valid_ff && !oq_full;
   assign tok_pop = tok_valid && (!s1_valid_ff || !oq_full);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (tok_pop) begin
         s1_valid_in = 1'b1;
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_pop) begin
         s1_rec_ff <= s1_rec_in;
         s1_n_ff   <= n1;
         s1_off_ff <= off1;
         s1_m_ff   <= m1;
      end
   end

   // A refused list match still ends the search; only the strip is skipped.
   always_comb begin
      strip   = (s1_m_ff != 4'd0)
                && ({1'b0, s1_n_ff} >= min_x + (LEN_W + 1)'(s1_m_ff));
      n2      = strip ? s1_n_ff - LEN_W'(s1_m_ff) : s1_n_ff;
      off2    = TAIL_IDX_W'(s1_off_ff) + (strip ? TAIL_IDX_W'(s1_m_ff) : '0);
      off2_hi = off2 + 1'b1;
      sign    = s1_rec_ff.eligible
                && (s1_rec_ff.win[off2_hi] == LEAD_D1)
                && ((s1_rec_ff.win[off2] == TRAIL_SFT) || (s1_rec_ff.win[off2] == TRAIL_HRD))
                && ({1'b0, n2} >= min_x + (LEN_W + 1)'(2));
      n3      = sign ? n2 - LEN_W'(2) : n2;
      res.stem_length = n3;
      res.was_changed = (n3 != s1_rec_ff.len);
      res.too_long    = s1_rec_ff.too_long;
   end

   assign empty  = (oq_cnt_ff == '0);
   assign oq_rd  = pop && !empty;

   assign rsp_stem_length = oq_ff[oq_rptr_ff].stem_length;
   assign rsp_was_changed = oq_ff[oq_rptr_ff].was_changed;
   assign rsp_too_long    = oq_ff[oq_rptr_ff].too_long;

   always_comb begin
      oq_wptr_in = s2_fire ? oq_wptr_ff + 1'b1 : oq_wptr_ff;
      oq_rptr_in = oq_rd ? oq_rptr_ff + 1'b1 : oq_rptr_ff;
      oq_cnt_in  = oq_cnt_ff;
      if (s2_fire && !oq_rd) begin
         oq_cnt_in = oq_cnt_ff + 1'b1;
      end else if (oq_rd && !s2_fire) begin
         oq_cnt_in = oq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         oq_ff[oq_wptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         oq_wptr_ff  <= '0;
         oq_rptr_ff  <= '0;
         oq_cnt_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         oq_wptr_ff  <= oq_wptr_in;
         oq_rptr_ff  <= oq_rptr_in;
         oq_cnt_ff   <= oq_cnt_in;
      end
   end

endmodule

`default_nettype wire

@@ design/russian_suffix_stemmer_top.sv @@
// Throughput: one token byte per cycle while full is low, and one result beat per cycle
// while empty is low. A result beat reaches the rsp_ ports through the
// token queue, the stage-one register and the result queue, any of which can stall it.
// Reset is synchronous and active high; it empties both queues, clears the token state and
// sets the minimum stem length back to 6. Queue storage itself is not cleared.
`default_nettype none

module russian_suffix_stemmer_top import rss_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input beats: one byte of a token each.
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [7:0]            req_token_byte,
   input  wire logic                  req_last_byte,
   // Result beats: one per token.
   output logic                       empty,
   input  wire logic                  pop,
   output logic [LEN_W-1:0]           rsp_stem_length,
   output logic                       rsp_was_changed,
   output logic                       rsp_too_long,
   // Configuration port.
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // The only register, the minimum stem length, sits at byte address zero. The
   // index is taken from paddr[2], so the low address bits are ignored.
   logic [MIN_W-1:0] min_stem_ff, min_stem_in;
   logic             csr_wr;
   logic             csr_hit;

   token_rec_type    rec_data;
   logic             rec_push;
   logic             rec_full;
   token_rec_type    tok_data;
   logic             tok_valid;
   logic             tok_pop;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == REG_MIN_STEM);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;

   assign min_stem_in = csr_wr ? pwdata[MIN_W-1:0] : min_stem_ff;
   assign prdata      = csr_hit ? {{(CSR_DATA_W - MIN_W){1'b0}}, min_stem_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_stem_ff <= MIN_STEM_RESET;
      end else begin
         min_stem_ff <= min_stem_in;
      end
   end

   // The front end counts bytes, tracks digits and Cyrillic lead bytes, and
   // keeps the last fourteen bytes. It stalls input only when the token queue
   // is full, so a waiting result never holds back incoming bytes directly.
   rss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_token_byte (req_token_byte),
      .req_last_byte  (req_last_byte),
      .rec_full       (rec_full),
      .rec_push       (rec_push),
      .rec_data       (rec_data)
   );

   // Each finished token waits here until the strip pipeline takes it.
   rss_tok_queue u_tok_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (rec_push),
      .wr_data  (rec_data),
      .wr_full  (rec_full),
      .rd_pop   (tok_pop),
      .rd_valid (tok_valid),
      .rd_data  (tok_data)
   );

   // The back end runs the reflexive strip, the ordered list search and the
   // soft or hard sign strip over two stages, then queues the result beat.
   rss_back u_back (
      .clock           (clock),
      .reset           (reset),
      .min_stem        (min_stem_ff),
      .tok_valid       (tok_valid),
      .tok_data        (tok_data),
      .tok_pop         (tok_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_stem_length (rsp_stem_length),
      .rsp_was_changed (rsp_was_changed),
      .rsp_too_long    (rsp_too_long)
   );

endmodule

`default_nettype wire

@@ design/rss_checker.sv @@
// Port-level checks for the stemmer top level, bound in below.
`default_nettype none

module rss_checker import rss_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             full,
   input wire logic             empty,
   input wire logic             pop,
   input wire logic [LEN_W-1:0] rsp_stem_length,
   input wire logic             rsp_was_changed,
   input wire logic             rsp_too_long
);

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_long_unchanged : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_too_long) |-> !rsp_was_changed)
      else $error("overlong token reported as changed");

   a_long_saturates : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_too_long) |-> (rsp_stem_length == MAX_TOKEN_BYTES))
      else $error("overlong token length not saturated");

   a_beat_holds : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_stem_length)
                            && $stable(rsp_was_changed) && $stable(rsp_too_long)))
      else $error("waiting result beat changed or vanished");

endmodule

bind russian_suffix_stemmer_top rss_checker u_rss_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_stem_length (rsp_stem_length),
   .rsp_was_changed (rsp_was_changed),
   .rsp_too_long    (rsp_too_long)
);

`default_nettype wire
